FILE: rtl/core/dbdpt_pkg.sv
// ----------------------------------------------------------------------------
// dbdpt_pkg
// Shared types and constants for the debounced button double-press toggle.
// ----------------------------------------------------------------------------
package dbdpt_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int CFG_WIDTH  = 16;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = CFG_WIDTH'(50);
    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET   = CFG_WIDTH'(1000);

    typedef enum logic [0:0] {
        CFG_DEBOUNCE_MS = 1'b0,
        CFG_WINDOW_MS   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PHASE_IDLE        = 2'd0,
        PHASE_WAIT_REL1   = 2'd1,
        PHASE_WAIT_PRESS2 = 2'd2,
        PHASE_WAIT_REL2   = 2'd3
    } phase_t;

    typedef struct packed {
        logic                  pin_level;
        logic [TIME_WIDTH-1:0] now_ms;
    } in_t;

    typedef struct packed {
        logic       fan_on;
        logic       button_stable;
        logic [1:0] press_phase;
    } out_t;

endpackage

FILE: rtl/core/debounced_button_double_press_toggle_unit.sv
// ----------------------------------------------------------------------------
// debounced_button_double_press_toggle_unit
// Debounces an active-low button sample stream and toggles a fan on a single
// press, off on a second press inside a configurable window.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transaction per pin sample with its millisecond timestamp.
//   out_*  : one transaction per input transaction, in order: fan level,
//            debounced button level and press phase after that sample.
//   cfg_*  : write cfg_data to register cfg_index when cfg_we is high
//            (0: debounce_ms, 1: double_press_window_ms). Write only while
//            no transaction is in flight.
// One input register feeds the update logic, which loads the output register.
// Throughput is one transaction per cycle while out_ready is high.
// Reset clears all state: fan off, phase idle, button released, debounce
// 50 ms, window 1000 ms.
// While out_ready is low the output holds; the input register takes one
// more transaction, then in_ready drops until the output drains.
// ----------------------------------------------------------------------------
module debounced_button_double_press_toggle_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dbdpt_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dbdpt_pkg::out_t                     out_data,
    input  logic                                cfg_we,
    input  dbdpt_pkg::cfg_index_t               cfg_index,
    input  logic [dbdpt_pkg::CFG_WIDTH-1:0]     cfg_data
);

    logic [dbdpt_pkg::CFG_WIDTH-1:0]  debounce_reg;
    logic [dbdpt_pkg::CFG_WIDTH-1:0]  window_reg;

    logic                             s1_valid_reg;
    dbdpt_pkg::in_t                   s1_data_reg;
    logic                             s1_move;

    logic                             out_valid_reg;
    dbdpt_pkg::out_t                  out_data_reg;

    logic                             fan_reg;
    logic                             fan_next;
    dbdpt_pkg::phase_t                phase_reg;
    dbdpt_pkg::phase_t                phase_next;
    logic [dbdpt_pkg::TIME_WIDTH-1:0] first_stamp_reg;
    logic [dbdpt_pkg::TIME_WIDTH-1:0] first_stamp_next;
    logic [dbdpt_pkg::TIME_WIDTH-1:0] db_start_reg;
    logic [dbdpt_pkg::TIME_WIDTH-1:0] db_start_next;
    logic                             stable_reg;
    logic                             stable_next;
    logic                             prev_raw_reg;

    logic                             raw;
    logic [dbdpt_pkg::TIME_WIDTH-1:0] now;
    logic [dbdpt_pkg::TIME_WIDTH-1:0] db_elapsed;
    logic [dbdpt_pkg::TIME_WIDTH-1:0] press_elapsed;
    logic                             in_window;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= dbdpt_pkg::DEBOUNCE_RESET;
            window_reg   <= dbdpt_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dbdpt_pkg::CFG_DEBOUNCE_MS: debounce_reg <= cfg_data;
                dbdpt_pkg::CFG_WINDOW_MS:   window_reg   <= cfg_data;
                default:                    debounce_reg <= debounce_reg;
            endcase
        end
    end

    // handshake
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg <= in_data;
        end
    end

    // update logic
    assign raw        = !s1_data_reg.pin_level;
    assign now        = s1_data_reg.now_ms;
    assign db_elapsed = (raw != prev_raw_reg) ? '0 : now - db_start_reg;

    always_comb
    begin
        db_start_next = (raw != prev_raw_reg) ? now : db_start_reg;
        stable_next   = (db_elapsed > dbdpt_pkg::TIME_WIDTH'(debounce_reg)) ? raw : stable_reg;
    end

    assign press_elapsed = now - first_stamp_reg;
    assign in_window     = press_elapsed <= dbdpt_pkg::TIME_WIDTH'(window_reg);

    always_comb
    begin
        phase_next       = phase_reg;
        fan_next         = fan_reg;
        first_stamp_next = first_stamp_reg;
        unique case (phase_reg)
            dbdpt_pkg::PHASE_IDLE:
            begin
                if (stable_next)
                begin
                    phase_next       = dbdpt_pkg::PHASE_WAIT_REL1;
                    first_stamp_next = now;
                    fan_next         = 1'b1;
                end
            end
            dbdpt_pkg::PHASE_WAIT_REL1:
            begin
                if (!stable_next)
                begin
                    phase_next = dbdpt_pkg::PHASE_WAIT_PRESS2;
                end
            end
            dbdpt_pkg::PHASE_WAIT_PRESS2:
            begin
                if (stable_next)
                begin
                    if (in_window)
                    begin
                        fan_next   = 1'b0;
                        phase_next = dbdpt_pkg::PHASE_WAIT_REL2;
                    end
                end
                else if (!in_window)
                begin
                    phase_next = dbdpt_pkg::PHASE_IDLE;
                end
            end
            dbdpt_pkg::PHASE_WAIT_REL2:
            begin
                if (!stable_next)
                begin
                    phase_next = dbdpt_pkg::PHASE_IDLE;
                end
            end
            default:
            begin
                phase_next = dbdpt_pkg::PHASE_IDLE;
            end
        endcase
    end

    // state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_reg         <= 1'b0;
            phase_reg       <= dbdpt_pkg::PHASE_IDLE;
            first_stamp_reg <= '0;
            db_start_reg    <= '0;
            stable_reg      <= 1'b0;
            prev_raw_reg    <= 1'b0;
        end
        else if (s1_move)
        begin
            fan_reg         <= fan_next;
            phase_reg       <= phase_next;
            first_stamp_reg <= first_stamp_next;
            db_start_reg    <= db_start_next;
            stable_reg      <= stable_next;
            prev_raw_reg    <= raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg.fan_on        <= fan_next;
            out_data_reg.button_stable <= stable_next;
            out_data_reg.press_phase   <= phase_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/dbdpt_check.sv
// ----------------------------------------------------------------------------
// dbdpt_check
// Port-level checks for the debounced button double-press toggle unit.
// ----------------------------------------------------------------------------
module dbdpt_check (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  dbdpt_pkg::out_t out_data
);

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // a new output comes from an input transaction that passed the input register
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("output without input transaction");

    // input side never blocks while the output is empty
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // waiting for first release means the fan is on and the button is held
    a_first_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.press_phase == dbdpt_pkg::PHASE_WAIT_REL1
        |-> out_data.fan_on && out_data.button_stable)
        else $error("first press phase inconsistent");

    // waiting for second release means the fan was switched off
    a_second_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.press_phase == dbdpt_pkg::PHASE_WAIT_REL2
        |-> !out_data.fan_on)
        else $error("second press left fan on");

endmodule

bind debounced_button_double_press_toggle_unit dbdpt_check u_dbdpt_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
